### hw/rtl/wtcs_pkg.sv
`default_nettype none
package wtcs_pkg;

	// default texture geometry
	localparam int TEX_SIZE_DEF     = 64;
	localparam int NUM_TEXTURES_DEF = 4;

	// decoupling queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	// per-channel halving for y-side hits
	localparam logic [23:0] HALVE_MASK = 24'h7F7F7F;

	// configuration port
	localparam int CFG_AW = 2;
	localparam int CFG_DW = 12;
	localparam logic [CFG_AW-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_AW-1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFG_DW-1:0] SCREEN_WIDTH_RST  = 12'd640;
	localparam logic [CFG_DW-1:0] SCREEN_HEIGHT_RST = 12'd480;

	// commands
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_SHADE = 1'b1;

	// numerator width: row - height/2 + lh/2 as signed
	localparam int NUM_W = 18;
	localparam int MAG_W = 17;

	// classified request handed from front to back
	typedef struct packed {
		logic              cmd;
		logic [1:0]        tid;
		logic [23:0]       texel;
		logic              side;
		logic              mirror;
		logic [31:0]       frac;
		logic [21:0]       pix;
		logic [NUM_W-1:0]  num;
		logic [15:0]       lh;
		logic [10:0]       col;
		logic [10:0]       row;
	} item_t;

endpackage
`default_nettype wire

### hw/rtl/wtcs_front.sv
`default_nettype none
module wtcs_front (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire  [wtcs_pkg::CFG_DW-1:0] screen_width,
	input  wire  [wtcs_pkg::CFG_DW-1:0] screen_height,
	input  wire                       in_valid,
	output logic                      in_ready,
	input  wire                       cmd,
	input  wire  [1:0]                tex_id,
	input  wire  [23:0]               texel_color,
	input  wire                       side,
	input  wire  [23:0]               pos_x,
	input  wire  [23:0]               pos_y,
	input  wire  [23:0]               perp_dist,
	input  wire  signed [17:0]        ray_dx,
	input  wire  signed [17:0]        ray_dy,
	input  wire  [15:0]               line_height,
	input  wire  [10:0]               column,
	input  wire  [10:0]               row,
	output logic                      q_valid,
	input  wire                       q_ready,
	output wtcs_pkg::item_t           q_item
);
	import wtcs_pkg::*;

	logic        v_s1, v_s2, adv2;
	logic        cmd_s1, side_s1, mirror_s1;
	logic [1:0]  tid_s1;
	logic [23:0] texel_s1, pos_s1;
	logic [31:0] prod_s1;
	logic [22:0] prow_s1;
	logic [NUM_W-1:0] num_s1;
	logic [15:0] lh_s1;
	logic [10:0] col_s1, row_s1;
	item_t       item_s2;

	logic signed [42:0] prod_c;
	logic signed [17:0] dir_c;
	logic [NUM_W-1:0]   num_c;

	// stall chain
	always_comb begin
		adv2     = !v_s2 || q_ready;
		in_ready = !v_s1 || adv2;
	end

	// hit product and row numerator
	always_comb begin
		dir_c  = side ? ray_dx : ray_dy;
		prod_c = $signed({19'd0, perp_dist}) * dir_c;
		num_c  = NUM_W'({7'd0, row}) - NUM_W'({7'd0, screen_height[CFG_DW-1:1]})
			+ NUM_W'({3'd0, line_height[15:1]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (adv2)     v_s2 <= v_s1;
		end
	end

	// stage 1: multiplies
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1    <= cmd;
			tid_s1    <= tex_id;
			texel_s1  <= texel_color;
			side_s1   <= side;
			mirror_s1 <= (!side && !ray_dx[17] && (ray_dx != 18'sd0)) || (side && ray_dy[17]);
			pos_s1    <= side ? pos_x : pos_y;
			prod_s1   <= prod_c[31:0];
			prow_s1   <= {12'd0, row} * {11'd0, screen_width};
			num_s1    <= num_c;
			lh_s1     <= line_height;
			col_s1    <= column;
			row_s1    <= row;
		end
	end

	// stage 2: hit fraction and frame buffer index
	always_ff @(posedge clk) begin
		if (v_s1 && adv2) begin
			item_s2.cmd    <= cmd_s1;
			item_s2.tid    <= tid_s1;
			item_s2.texel  <= texel_s1;
			item_s2.side   <= side_s1;
			item_s2.mirror <= mirror_s1;
			item_s2.frac   <= {pos_s1[15:0], 16'd0} + prod_s1;
			item_s2.pix    <= 22'(prow_s1 + 23'(col_s1));
			item_s2.num    <= num_s1;
			item_s2.lh     <= lh_s1;
			item_s2.col    <= col_s1;
			item_s2.row    <= row_s1;
		end
	end

	assign q_valid = v_s2;
	assign q_item  = item_s2;

endmodule
`default_nettype wire

### hw/rtl/wtcs_queue.sv
`default_nettype none
module wtcs_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push_valid,
	output logic             push_ready,
	input  wtcs_pkg::item_t  push_item,
	output logic             pop_valid,
	input  wire              pop,
	output wtcs_pkg::item_t  pop_item
);
	import wtcs_pkg::*;

	item_t           ent_q [QDEPTH];
	logic [QAW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QAW:0]    cnt_q;
	logic            do_push, do_pop;

	always_comb begin
		push_ready = (cnt_q != (QAW+1)'(QDEPTH));
		pop_valid  = (cnt_q != '0);
		do_push    = push_valid && push_ready;
		do_pop     = pop && pop_valid;
		pop_item   = ent_q[rd_ptr_q];
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) wr_ptr_q <= QAW'(wr_ptr_q + 1'b1);
			if (do_pop)  rd_ptr_q <= QAW'(rd_ptr_q + 1'b1);
			if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) ent_q[wr_ptr_q] <= push_item;
	end

endmodule
`default_nettype wire

### hw/rtl/wtcs_back.sv
`default_nettype none
module wtcs_back #(
	parameter int TEX_SIZE     = wtcs_pkg::TEX_SIZE_DEF,
	parameter int NUM_TEXTURES = wtcs_pkg::NUM_TEXTURES_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              q_valid,
	input  wtcs_pkg::item_t  q_item,
	output logic             q_pop,
	output logic             out_valid,
	input  wire              out_ready,
	output logic [21:0]      pixel_index,
	output logic [23:0]      color,
	output logic [5:0]       tex_col,
	output logic [5:0]       tex_row
);
	import wtcs_pkg::*;

	localparam int TW    = $clog2(TEX_SIZE);
	localparam int NW    = MAG_W + TW;
	localparam int DEPTH = NUM_TEXTURES * TEX_SIZE * TEX_SIZE;
	localparam int AW    = $clog2(DEPTH);

	typedef struct packed {
		logic          cmd;
		logic [1:0]    tid;
		logic [23:0]   texel;
		logic          side;
		logic [TW-1:0] tcol;
		logic [21:0]   pix;
		logic          neg;
		logic          lhz;
		logic          ld_ok;
		logic [TW-1:0] ld_col;
		logic [TW-1:0] ld_row;
		logic [15:0]   lh;
	} meta_t;

	logic          en;
	meta_t         dv_meta_s [NW+1];
	logic          dv_v_s    [NW+1];
	logic [16:0]   dv_rem_s  [NW+1];
	logic [NW-1:0] dv_dvd_s  [NW+1];
	logic [TW-1:0] dv_q_s    [NW+1];

	meta_t            m0_c;
	logic [MAG_W-1:0] mag_c;
	logic [TW-1:0]    tcol_raw_c;

	// whole back end moves when the output register frees up
	assign en    = !out_valid || out_ready;
	assign q_pop = en && q_valid;

	// entry: texture column, numerator sign and magnitude, load checks
	always_comb begin
		tcol_raw_c   = q_item.frac[31 -: TW];
		mag_c        = MAG_W'(q_item.num[NUM_W-1] ? -q_item.num : q_item.num);
		m0_c.cmd     = q_item.cmd;
		m0_c.tid     = q_item.tid;
		m0_c.texel   = q_item.texel;
		m0_c.side    = q_item.side;
		m0_c.tcol    = q_item.mirror ? ~tcol_raw_c : tcol_raw_c;
		m0_c.pix     = q_item.pix;
		m0_c.neg     = q_item.num[NUM_W-1];
		m0_c.lhz     = (q_item.lh == 16'd0);
		m0_c.ld_ok   = (32'(q_item.tid) < NUM_TEXTURES) && (32'(q_item.col) < TEX_SIZE)
			&& (32'(q_item.row) < TEX_SIZE);
		m0_c.ld_col  = q_item.col[TW-1:0];
		m0_c.ld_row  = q_item.row[TW-1:0];
		m0_c.lh      = q_item.lh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v_s[0] <= 1'b0;
		else if (en) dv_v_s[0] <= q_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_meta_s[0] <= m0_c;
			dv_rem_s[0]  <= '0;
			dv_dvd_s[0]  <= {mag_c, TW'(0)};
			dv_q_s[0]    <= '0;
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 0; k < NW; k++) begin : g_div
		logic [16:0] rs;
		logic        ge;
		assign rs = {dv_rem_s[k][15:0], dv_dvd_s[k][NW-1]};
		assign ge = (rs >= {1'b0, dv_meta_s[k].lh});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[k+1] <= 1'b0;
			else if (en) dv_v_s[k+1] <= dv_v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_meta_s[k+1] <= dv_meta_s[k];
				dv_rem_s[k+1]  <= ge ? 17'(rs - {1'b0, dv_meta_s[k].lh}) : rs;
				dv_dvd_s[k+1]  <= NW'({dv_dvd_s[k], 1'b0});
				dv_q_s[k+1]    <= TW'({dv_q_s[k], ge});
			end
		end
	end

	// texture row and store addresses
	meta_t         mf;
	logic [TW-1:0] trow_c;
	logic [AW-1:0] rd_addr_c, wr_addr_c;
	logic          tid_ok_c;

	always_comb begin
		mf        = dv_meta_s[NW];
		trow_c    = mf.lhz ? '0 : (mf.neg ? TW'(-dv_q_s[NW]) : dv_q_s[NW]);
		rd_addr_c = AW'({mf.tid, trow_c, mf.tcol});
		wr_addr_c = AW'({mf.tid, mf.ld_row, mf.ld_col});
		tid_ok_c  = (32'(mf.tid) < NUM_TEXTURES);
	end

	// texture store
	logic [23:0]   tex_mem [DEPTH];
	logic [23:0]   rdata_q;
	logic          rd_v_s1, rd_cmd_s1, rd_side_s1, rd_ok_s1;
	logic [21:0]   rd_pix_s1;
	logic [TW-1:0] rd_tcol_s1, rd_trow_s1;

	always_ff @(posedge clk) begin
		if (en && dv_v_s[NW] && (mf.cmd == CMD_LOAD) && mf.ld_ok)
			tex_mem[wr_addr_c] <= mf.texel;
		if (en && dv_v_s[NW] && (mf.cmd == CMD_SHADE))
			rdata_q <= tex_mem[rd_addr_c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_v_s1 <= 1'b0;
		else if (en) rd_v_s1 <= dv_v_s[NW] && (mf.cmd == CMD_SHADE);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_cmd_s1  <= mf.cmd;
			rd_side_s1 <= mf.side;
			rd_ok_s1   <= tid_ok_c;
			rd_pix_s1  <= mf.pix;
			rd_tcol_s1 <= mf.tcol;
			rd_trow_s1 <= trow_c;
		end
	end

	// output register
	logic        out_valid_q;
	logic [23:0] color_c;

	always_comb begin
		color_c = rd_ok_s1 ? rdata_q : 24'd0;
		if (rd_side_s1) color_c = (color_c >> 1) & HALVE_MASK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= rd_v_s1 && (rd_cmd_s1 == CMD_SHADE);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pixel_index <= rd_pix_s1;
			color       <= color_c;
			tex_col     <= 6'(rd_tcol_s1);
			tex_row     <= 6'(rd_trow_s1);
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

### hw/rtl/wall_texture_column_shader.sv
`default_nettype none
// Channel | Handshake           | Payload
// in      | in_valid/in_ready   | cmd tex_id texel_color side pos_x pos_y perp_dist
//         |                     | ray_dx ray_dy line_height column row
// out     | out_valid/out_ready | pixel_index color tex_col tex_row
// cfg     | cfg_we              | cfg_addr cfg_wdata
//
// One request per clock sustained while out_ready stays high. A result passes through
// 2 front stages, the queue, the divider entry register, log2(TEX_SIZE)+17
// divider stages, the store read and the output register.
// The row divider sets the depth.
// Reset clears control only; texture store contents are undefined until loaded.
// Output stall freezes the back end; the 4-entry queue and the front stages fill,
// then in_ready drops.
module wall_texture_column_shader #(
	parameter int TEX_SIZE     = wtcs_pkg::TEX_SIZE_DEF,
	parameter int NUM_TEXTURES = wtcs_pkg::NUM_TEXTURES_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire  [wtcs_pkg::CFG_AW-1:0] cfg_addr,
	input  wire  [wtcs_pkg::CFG_DW-1:0] cfg_wdata,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire                         cmd,
	input  wire  [1:0]                  tex_id,
	input  wire  [23:0]                 texel_color,
	input  wire                         side,
	input  wire  [23:0]                 pos_x,
	input  wire  [23:0]                 pos_y,
	input  wire  [23:0]                 perp_dist,
	input  wire  signed [17:0]          ray_dx,
	input  wire  signed [17:0]          ray_dy,
	input  wire  [15:0]                 line_height,
	input  wire  [10:0]                 column,
	input  wire  [10:0]                 row,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic [21:0]                 pixel_index,
	output logic [23:0]                 color,
	output logic [5:0]                  tex_col,
	output logic [5:0]                  tex_row
);
	import wtcs_pkg::*;

	logic [CFG_DW-1:0] screen_width_q, screen_height_q;
	logic  fq_valid, fq_ready, bq_valid, bq_pop;
	item_t fq_item, bq_item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	wtcs_front u_front (
		.clk(clk), .arst_n(arst_n),
		.screen_width(screen_width_q), .screen_height(screen_height_q),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .tex_id(tex_id), .texel_color(texel_color), .side(side),
		.pos_x(pos_x), .pos_y(pos_y), .perp_dist(perp_dist),
		.ray_dx(ray_dx), .ray_dy(ray_dy), .line_height(line_height),
		.column(column), .row(row),
		.q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item)
	);

	wtcs_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(fq_valid), .push_ready(fq_ready), .push_item(fq_item),
		.pop_valid(bq_valid), .pop(bq_pop), .pop_item(bq_item)
	);

	wtcs_back #(.TEX_SIZE(TEX_SIZE), .NUM_TEXTURES(NUM_TEXTURES)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(bq_valid), .q_item(bq_item), .q_pop(bq_pop),
		.out_valid(out_valid), .out_ready(out_ready),
		.pixel_index(pixel_index), .color(color),
		.tex_col(tex_col), .tex_row(tex_row)
	);

endmodule
`default_nettype wire

### hw/rtl/wtcs_checker.sv
`default_nettype none
module wtcs_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [21:0] pixel_index,
	input wire [23:0] color
);

	// no result straight out of reset
	a_reset_quiet: assert property (@(posedge clk) !$past(arst_n) |-> !out_valid)
		else $error("result shown right after reset");

	// input held off again only if the output is stalled
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_ready && $past(!in_ready) && $past(arst_n)) |-> $past(out_valid && !out_ready))
		else $error("input stalled without output backpressure");

	// a stalled result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(pixel_index) && $stable(color)))
		else $error("stalled result changed");

endmodule

bind wall_texture_column_shader wtcs_checker u_wtcs_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready),
	.pixel_index(pixel_index), .color(color)
);
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import wtcs_pkg::*;

	localparam int TEX = 64;
	localparam int NTEX = 4;
	localparam int LATENCY = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_AW-1:0] cfg_addr = '0;
	logic [CFG_DW-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = CMD_LOAD;
	logic [1:0] tex_id = '0;
	logic [23:0] texel_color = '0;
	logic side = 1'b0;
	logic [23:0] pos_x = '0, pos_y = '0, perp_dist = '0;
	logic signed [17:0] ray_dx = '0, ray_dy = '0;
	logic [15:0] line_height = 16'd1;
	logic [10:0] column = '0, row = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [21:0] pixel_index;
	logic [23:0] color;
	logic [5:0] tex_col, tex_row;

	typedef struct {
		logic [21:0] pix;
		logic [23:0] rgb;
		logic [5:0] tcol;
		logic [5:0] trow;
	} pixel_t;

	// predictor state
	logic [23:0] tex_mem [NTEX*TEX*TEX];
	bit tex_loaded [NTEX*TEX*TEX];
	logic [11:0] scr_w = 12'd640, scr_h = 12'd480;
	pixel_t pending_pixels [$];
	int errors = 0;
	int mismatches = 0;
	bit in_idle_en = 1'b1, out_idle_en = 1'b1;
	int out_holdoff = 0;
	int out_burst = 0;

	wall_texture_column_shader dut (.*);

	always #5 clk = ~clk;

	// texture column after hit fraction and mirroring
	function automatic logic [5:0] calc_tcol(logic sd, logic [23:0] px, logic [23:0] py,
			logic [23:0] pd, logic signed [17:0] dx, logic signed [17:0] dy);
		logic [63:0] hit;
		logic [31:0] frac;
		logic [5:0] c;
		if (sd == 1'b0)
			hit = {24'd0, py, 16'd0} + {40'd0, pd} * {{46{dy[17]}}, dy};
		else
			hit = {24'd0, px, 16'd0} + {40'd0, pd} * {{46{dx[17]}}, dx};
		frac = hit[31:0];
		c = frac[31:26];
		if ((sd == 1'b0 && dx > 0) || (sd == 1'b1 && dy < 0))
			c = 6'(TEX - 1 - c);
		return c;
	endfunction

	// texture row: exact quotient truncated toward zero, masked
	function automatic logic [5:0] calc_trow(logic [10:0] r, logic [15:0] lh);
		longint n;
		if (lh == 0)
			return '0;
		n = longint'(r) - longint'(scr_h / 2) + longint'(lh / 2);
		n = (n * TEX) / longint'(lh);
		return 6'(n);
	endfunction

	function automatic int tex_addr(logic [1:0] tid, logic [5:0] tr, logic [5:0] tc);
		return (int'(tid) * TEX + int'(tr)) * TEX + int'(tc);
	endfunction

	// check each completed pixel against the oldest prediction
	always @(posedge clk) begin
		pixel_t exp_px;
		if (out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				errors++;
				if (mismatches++ < 10)
					$display("unexpected pixel idx=%0d color=%h", pixel_index, color);
			end else begin
				exp_px = pending_pixels.pop_front();
				if (pixel_index !== exp_px.pix || color !== exp_px.rgb ||
						tex_col !== exp_px.tcol || tex_row !== exp_px.trow) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch exp idx=%0d col=%h tc=%0d tr=%0d got idx=%0d col=%h tc=%0d tr=%0d",
							exp_px.pix, exp_px.rgb, exp_px.tcol, exp_px.trow,
							pixel_index, color, tex_col, tex_row);
				end
			end
		end
	end

	// receiver: random stall bursts, plus a long hold-off on request
	always @(negedge clk) begin
		if (out_holdoff > 0) begin
			out_holdoff--;
			out_ready <= 1'b0;
		end else if (out_burst > 0) begin
			out_burst--;
			out_ready <= 1'b0;
		end else if (out_idle_en && $urandom_range(0, 9) == 0) begin
			out_burst = $urandom_range(0, 7);
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SCREEN_WIDTH)
			scr_w = val;
		else if (idx == REG_SCREEN_HEIGHT)
			scr_h = val;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	// send one request; predict its pixel on acceptance
	task automatic send_request(logic c, logic [1:0] tid, logic [23:0] tx, logic sd,
			logic [23:0] px, logic [23:0] py, logic [23:0] pd,
			logic signed [17:0] dx, logic signed [17:0] dy, logic [15:0] lh,
			logic [10:0] cl, logic [10:0] rw);
		pixel_t p;
		int addr;
		int gap;
		if (in_idle_en && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c; tex_id <= tid; texel_color <= tx; side <= sd;
		pos_x <= px; pos_y <= py; perp_dist <= pd; ray_dx <= dx; ray_dy <= dy;
		line_height <= lh; column <= cl; row <= rw;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (c == CMD_LOAD) begin
			if (tid < NTEX && cl < TEX && rw < TEX) begin
				addr = (int'(tid) * TEX + int'(rw)) * TEX + int'(cl);
				tex_mem[addr] = tx;
				tex_loaded[addr] = 1'b1;
			end
		end else begin
			p.tcol = calc_tcol(sd, px, py, pd, dx, dy);
			p.trow = calc_trow(rw, lh);
			p.rgb = '0;
			if (tid < NTEX)
				p.rgb = tex_mem[(int'(tid) * TEX + int'(p.trow)) * TEX + int'(p.tcol)];
			if (sd)
				p.rgb = (p.rgb >> 1) & HALVE_MASK;
			p.pix = 22'(int'(rw) * int'(scr_w) + int'(cl));
			pending_pixels.push_back(p);
		end
		@(negedge clk);
	endtask

	// shade one pixel; its texel is loaded first if it never was
	task automatic shade_item(logic [1:0] tid, logic [23:0] tx, logic sd,
			logic [23:0] px, logic [23:0] py, logic [23:0] pd,
			logic signed [17:0] dx, logic signed [17:0] dy, logic [15:0] lh,
			logic [10:0] cl, logic [10:0] rw);
		logic [5:0] tc, tr;
		tc = calc_tcol(sd, px, py, pd, dx, dy);
		tr = calc_trow(rw, lh);
		if (!tex_loaded[tex_addr(tid, tr, tc)])
			send_request(CMD_LOAD, tid, 24'($urandom), 1'($urandom), 24'($urandom),
				24'($urandom), 24'($urandom), 18'($urandom), 18'($urandom),
				16'($urandom), 11'(tc), 11'(tr));
		send_request(CMD_SHADE, tid, tx, sd, px, py, pd, dx, dy, lh, cl, rw);
	endtask

	// scattered texels of random textures with random colors, first two white and black
	task automatic test_texture_load();
		int t, r, c;
		logic [23:0] rgb;
		for (int i = 0; i < 400; i++) begin
			t = $urandom_range(0, NTEX - 1);
			r = $urandom_range(0, TEX - 1);
			c = $urandom_range(0, TEX - 1);
			rgb = 24'($urandom);
			if (i == 0) begin
				t = 0; r = 0; c = 0; rgb = 24'hFFFFFF;
			end else if (i == 1) begin
				t = 0; r = 1; c = 0; rgb = 24'h000000;
			end
			send_request(CMD_LOAD, 2'(t), rgb,
				1'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
				18'($urandom), 18'($urandom), 16'($urandom),
				11'(c), 11'(r));
		end
	endtask

	// random shade with all fields, aimed at a texel that is already loaded
	task automatic random_shade(int lh_max);
		logic [15:0] lh;
		logic sd;
		logic [23:0] px, py, pd;
		logic signed [17:0] dx, dy;
		logic [10:0] cl, rw;
		logic [1:0] tid;
		logic [5:0] tc, tr;
		bit found;
		int base;
		found = 1'b0;
		tid = '0;
		for (int k = 0; k < 1000 && !found; k++) begin
			lh = 16'($urandom_range(1, lh_max));
			if ($urandom_range(0, 15) == 0)
				lh = 16'($urandom_range(0, 65535));
			sd = 1'($urandom);
			px = 24'($urandom); py = 24'($urandom); pd = 24'($urandom);
			dx = 18'($urandom); dy = 18'($urandom);
			cl = 11'($urandom); rw = 11'($urandom);
			tc = calc_tcol(sd, px, py, pd, dx, dy);
			tr = calc_trow(rw, lh);
			base = $urandom_range(0, NTEX - 1);
			for (int j = 0; j < NTEX && !found; j++) begin
				tid = 2'((base + j) % NTEX);
				found = tex_loaded[tex_addr(tid, tr, tc)];
			end
		end
		shade_item(tid, 24'($urandom), sd, px, py, pd, dx, dy, lh, cl, rw);
	endtask

	task automatic test_directed();
		// extremes of fields, zero height, mirroring both sides, out-of-range loads
		shade_item(2'd0, '0, 1'b0, '0, '0, '0, '0, '0, 16'd0, '0, '0);
		shade_item(2'd3, '1, 1'b1, '1, '1, '1, 18'sh1FFFF, 18'sh20000,
			16'hFFFF, 11'h7FF, 11'h7FF);
		shade_item(2'd1, '0, 1'b0, 24'h123456, 24'h654321, 24'h010000,
			18'sh10000, -18'sh08000, 16'd1, 11'd5, 11'd0);
		shade_item(2'd2, '0, 1'b1, 24'h0ABCDE, 24'h0, 24'h020000,
			-18'sh1, 18'sh10000, 16'd7, 11'd639, 11'd479);
		shade_item(2'd2, '0, 1'b1, 24'h0ABCDE, 24'h0, 24'h020000,
			18'sh1, -18'sh10000, 16'd100, 11'd0, 11'd0);
		shade_item(2'd1, '0, 1'b0, 24'h0, 24'hFFFF, '1, 18'sh20000,
			18'sh1FFFF, 16'd2, 11'd1000, 11'd2047);
		// loads out of range are ignored
		send_request(CMD_LOAD, 2'd0, 24'hDEAD00, 1'b0, '0, '0, '0, '0, '0, 16'd1,
			11'd64, 11'd0);
		send_request(CMD_LOAD, 2'd0, 24'hDEAD01, 1'b0, '0, '0, '0, '0, '0, 16'd1,
			11'd0, 11'd2047);
		for (int i = 0; i < 10; i++)
			random_shade(4);
	endtask

	task automatic test_random(int n, int lh_max);
		for (int i = 0; i < n; i++)
			if ($urandom_range(0, 9) == 0)
				send_request(CMD_LOAD, 2'($urandom), 24'($urandom), 1'($urandom),
					24'($urandom), 24'($urandom), 24'($urandom), 18'($urandom),
					18'($urandom), 16'($urandom), 11'($urandom_range(0, 80)),
					11'($urandom_range(0, 80)));
			else
				random_shade(lh_max);
	endtask

	// output held off while requests keep coming, so the input must stall
	task automatic test_backpressure();
		out_holdoff = 200;
		test_random(60, 600);
		wait_drained();
	endtask

	task automatic test_config_sweep();
		write_reg(REG_SCREEN_WIDTH, 12'd1);
		write_reg(REG_SCREEN_HEIGHT, 12'd1);
		test_random(200, 64);
		wait_drained();
		write_reg(REG_SCREEN_WIDTH, 12'd2048 - 12'd1);
		write_reg(REG_SCREEN_HEIGHT, 12'd0);
		test_random(200, 3000);
		wait_drained();
		write_reg(REG_SCREEN_WIDTH, 12'hFFF);
		write_reg(REG_SCREEN_HEIGHT, 12'hFFF);
		test_random(200, 65535);
		wait_drained();
		write_reg(REG_SCREEN_WIDTH, 12'($urandom_range(1, 2048)));
		write_reg(REG_SCREEN_HEIGHT, 12'($urandom_range(1, 2048)));
		test_random(200, 1000);
		wait_drained();
	endtask

	// no idling at the end: full rate
	task automatic test_full_rate();
		in_idle_en = 1'b0;
		out_idle_en = 1'b0;
		write_reg(REG_SCREEN_WIDTH, 12'd640);
		write_reg(REG_SCREEN_HEIGHT, 12'd480);
		test_random(300, 480);
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_texture_load();
		test_directed();
		wait_drained();
		test_random(200, 200);
		wait_drained();
		test_backpressure();
		test_config_sweep();
		test_full_rate();
		wait_drained();
		if (errors == 0 && pending_pixels.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/wtcs_pkg.sv
hw/rtl/wtcs_front.sv
hw/rtl/wtcs_queue.sv
hw/rtl/wtcs_back.sv
hw/rtl/wall_texture_column_shader.sv
hw/rtl/wtcs_checker.sv
tb/sv/tb_top.sv
